[hw/rtl/thc_pkg.sv]
// Shared types and constants of the thermistor fan controller.
// No dependencies; every other file of the block but thc_queue imports this package.
package thc_pkg;

    typedef struct packed {
        logic        cmd;
        logic [11:0] ref_mv;
        logic [11:0] pit_mv;
        logic [11:0] food_mv;
    } item_t;

    typedef struct packed {
        logic signed [15:0] pit_temp;
        logic signed [15:0] food_temp;
        logic [6:0]         fan_duty;
    } result_t;

    typedef struct packed {
        logic signed [47:0] coeff_a;
        logic signed [47:0] coeff_b;
        logic signed [47:0] coeff_c;
        logic [1:0]         fan_mode;
        logic [6:0]         manual_duty;
        logic [6:0]         auto_duty;
        logic [13:0]        target_temp;
        logic [11:0]        hysteresis;
    } cfg_t;

    // multiplier request and response
    typedef struct packed {
        logic               start;
        logic               sh32;
        logic signed [63:0] x;
        logic signed [63:0] y;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic signed [63:0] prod;
    } mul_rsp_t;

    typedef enum logic {F_IDLE, F_UPD} front_state_t;

    typedef enum logic [3:0] {
        B_IDLE, B_SETUP, B_NORM, B_LOG, B_MSTART, B_MWAIT,
        B_DEN, B_CHK, B_DIV, B_FIN, B_NEXT, B_DUTY
    } back_state_t;

    typedef enum logic [2:0] {OP_LN, OP_SQ, OP_CUBE, OP_LIN, OP_CUB} mul_op_t;

    // register indexes
    localparam logic [2:0] REG_COEFF_A     = 3'd0;
    localparam logic [2:0] REG_COEFF_B     = 3'd1;
    localparam logic [2:0] REG_COEFF_C     = 3'd2;
    localparam logic [2:0] REG_FAN_MODE    = 3'd3;
    localparam logic [2:0] REG_MANUAL_DUTY = 3'd4;
    localparam logic [2:0] REG_AUTO_DUTY   = 3'd5;
    localparam logic [2:0] REG_TARGET_TEMP = 3'd6;
    localparam logic [2:0] REG_HYSTERESIS  = 3'd7;

    localparam logic [1:0] MODE_AUTO   = 2'd0;
    localparam logic [1:0] MODE_MANUAL = 2'd1;

    localparam logic [6:0]         DUTY_MAX    = 7'd100;
    localparam logic [63:0]        LN2_Q32     = 64'h0000_0000_B172_17F8;
    localparam logic signed [63:0] K_OFFSET_Q8 = 64'sd1882808;
    localparam logic [55:0]        RECIP_NUM   = 56'd144 << 48;
    localparam logic signed [15:0] TEMP_LOW    = -16'sd16384;
    localparam logic signed [15:0] TEMP_HIGH   = 16'sd32767;

endpackage

[hw/rtl/thc_queue.sv]
// Two-entry job queue between the sample front end and the conversion engine.
// Depends on nothing but its width parameter.
module thc_queue #(
    parameter int WIDTH = 54
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             not_full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);
    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign not_full  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    // hold payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end
endmodule

[hw/rtl/thc_front.sv]
// Front end: takes items, keeps the sample ring and channel sums, queues reports.
// Depends on thc_pkg.
module thc_front #(
    parameter int W  = 64,
    parameter int VB = 12,
    parameter int PW = 6,
    parameter int SW = 18
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  thc_pkg::item_t    item,
    input  logic              q_ready,
    output logic              q_push,
    output logic [3*SW-1:0]   q_data
);
    import thc_pkg::*;

    front_state_t    state_reg, state_next;
    logic [PW-1:0]   pos_reg, pos_inc;
    logic            full_reg;
    logic            old_ok_reg;
    logic [3*VB-1:0] ring_mem [W];
    logic [3*VB-1:0] rd_reg;
    logic [3*VB-1:0] new_reg;
    logic [SW-1:0]   sums_reg [3];
    logic            accept, take_sample;

    assign pos_inc = (pos_reg == PW'(W - 1)) ? '0 : pos_reg + 1'b1;
    assign q_data  = {sums_reg[2], sums_reg[1], sums_reg[0]};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:  if (take_sample) state_next = F_UPD;
            F_UPD:   state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        item_ready  = (state_reg == F_IDLE) && q_ready;
        accept      = item_valid && item_ready;
        take_sample = accept && !item.cmd;
        q_push      = accept && item.cmd;
    end

    // ring memory: read the slot being replaced, write the new sample into it in the next cycle
    always_ff @(posedge clk)
    begin
        if (take_sample)
        begin
            rd_reg  <= ring_mem[pos_inc];
            new_reg <= {VB'(item.food_mv), VB'(item.pit_mv), VB'(item.ref_mv)};
        end
        if (state_reg == F_UPD)
        begin
            ring_mem[pos_reg] <= new_reg;
        end
    end

    // control state and running sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            pos_reg    <= '0;
            full_reg   <= 1'b0;
            old_ok_reg <= 1'b0;
            for (int c = 0; c < 3; c++)
            begin
                sums_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (take_sample)
            begin
                pos_reg    <= pos_inc;
                old_ok_reg <= full_reg;
                if (pos_inc == '0)
                begin
                    full_reg <= 1'b1;
                end
            end
            if (state_reg == F_UPD)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    sums_reg[c] <= SW'({1'b0, sums_reg[c]}
                        + (SW+1)'(new_reg[c*VB +: VB])
                        - (old_ok_reg ? (SW+1)'(rd_reg[c*VB +: VB]) : '0));
                end
            end
        end
    end
endmodule

[hw/rtl/thc_mul.sv]
// Shared signed multiplier: 64x64 from four 32x32 partial products,
// then shift right by 24 or 32, truncate toward zero and saturate. Depends on thc_pkg.
module thc_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  thc_pkg::mul_req_t req,
    output thc_pkg::mul_rsp_t rsp
);
    import thc_pkg::*;

    logic               busy_reg, fin_reg, done_reg;
    logic [1:0]         step_reg;
    logic [63:0]        xm_reg, ym_reg;
    logic               neg_reg, sh32_reg;
    logic [127:0]       acc_reg, acc_next;
    logic signed [63:0] prod_reg;
    logic [31:0]        xh, yh;
    logic [63:0]        pp;
    logic [127:0]       pp_sh;
    logic [63:0]        shifted, mag;
    logic               ovf;

    // select partial product and accumulate
    always_comb
    begin
        xh = step_reg[1] ? xm_reg[63:32] : xm_reg[31:0];
        yh = step_reg[0] ? ym_reg[63:32] : ym_reg[31:0];
        pp = xh * yh;
        case (step_reg)
            2'd0:    pp_sh = {64'b0, pp};
            2'd3:    pp_sh = {pp, 64'b0};
            default: pp_sh = {32'b0, pp, 32'b0};
        endcase
        acc_next = acc_reg + pp_sh;
    end

    // shift, saturate
    always_comb
    begin
        shifted = sh32_reg ? acc_reg[95:32] : acc_reg[87:24];
        ovf     = sh32_reg ? (|acc_reg[127:95]) : (|acc_reg[127:87]);
        mag     = ovf ? 64'h7FFF_FFFF_FFFF_FFFF : shifted;
    end

    assign rsp.done = done_reg;
    assign rsp.prod = prod_reg;

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            xm_reg   <= req.x[63] ? 64'(-req.x) : 64'(req.x);
            ym_reg   <= req.y[63] ? 64'(-req.y) : 64'(req.y);
            neg_reg  <= req.x[63] ^ req.y[63];
            sh32_reg <= req.sh32;
            acc_reg  <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
        if (fin_reg)
        begin
            prod_reg <= neg_reg ? -$signed(mag) : $signed(mag);
        end
    end

    // sequence the four partial products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= busy_reg && (step_reg == 2'd3);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end
endmodule

[hw/rtl/thc_back.sv]
// Conversion engine: log2, Steinhart-Hart, reciprocal and fan duty for each report.
// Depends on thc_pkg and drives the shared multiplier thc_mul.
module thc_back #(
    parameter int SW          = 18,
    parameter int SERIES_OHMS = 10000
) (
    input  logic              clk,
    input  logic              rst_n,
    input  thc_pkg::cfg_t     cfg,
    input  logic              job_valid,
    output logic              job_pop,
    input  logic [3*SW-1:0]   job,
    output thc_pkg::mul_req_t mul_req,
    input  thc_pkg::mul_rsp_t mul_rsp,
    output logic              result_valid,
    input  logic              result_ready,
    output thc_pkg::result_t  result
);
    import thc_pkg::*;

    localparam int OW = $clog2(SERIES_OHMS + 1);

    back_state_t        state_reg, state_next;
    logic               probe_reg, which_reg;
    logic [SW-1:0]      sref_reg, spit_reg, sfood_reg;
    logic [63:0]        d_reg, nrm_reg;
    logic [5:0]         exp_reg, cnt_reg;
    logic [30:0]        m_reg;
    logic [23:0]        frac_reg;
    logic [29:0]        logn_reg;
    logic signed [30:0] lg_reg;
    mul_op_t            op_reg;
    logic signed [63:0] l_reg, t_reg, mb_reg, mc_reg, den_reg;
    logic               neg_reg;
    logic [58:0]        dv_reg, rem_reg;
    logic [55:0]        dvd_reg, q_reg;
    logic signed [15:0] tmp_reg, pit_t_reg, food_t_reg;
    logic [6:0]         held_reg;
    logic               out_valid_reg;
    result_t            out_reg;

    logic [SW-1:0]      sp;
    logic [SW+OW-1:0]   sp_ohm;
    logic [SW:0]        sref2, sp_x, dval;
    logic               bad;
    logic [61:0]        sq;
    logic [31:0]        t32;
    logic [30:0]        m_nx;
    logic [23:0]        frac_nx;
    logic [63:0]        mag;
    logic [59:0]        rem_sh;
    logic               ge;
    logic signed [63:0] qs, v;
    logic signed [55:0] w;
    logic signed [15:0] temp_sat;
    logic signed [16:0] lo_th, hi_th, pit17;
    logic [6:0]         man_cap, auto_cap, duty_nx;
    logic               out_load;

    // probe operands and divider resistance
    always_comb
    begin
        sp     = probe_reg ? sfood_reg : spit_reg;
        sp_ohm = sp * OW'(SERIES_OHMS);
        sref2  = {sref_reg, 1'b0};
        sp_x   = {1'b0, sp};
        bad    = (sp == '0) || (sref2 <= sp_x);
        dval   = sref2 - sp_x;
    end

    // one squaring step of the log2 mantissa
    always_comb
    begin
        sq      = m_reg * m_reg;
        t32     = sq[61:30];
        m_nx    = t32[31] ? t32[31:1] : t32[30:0];
        frac_nx = {frac_reg[22:0], t32[31]};
    end

    // denominator magnitude and one restoring division step
    always_comb
    begin
        mag    = den_reg[63] ? 64'(-den_reg) : 64'(den_reg);
        rem_sh = {rem_reg, dvd_reg[55]};
        ge     = rem_sh >= {1'b0, dv_reg};
    end

    // Kelvin to 1/16 degF, round half up, saturate
    always_comb
    begin
        qs = neg_reg ? -$signed({8'b0, q_reg}) : $signed({8'b0, q_reg});
        v  = qs - K_OFFSET_Q8;
        w  = 56'((v + 64'sd128) >>> 8);
        if (w < 56'(TEMP_LOW))
        begin
            temp_sat = TEMP_LOW;
        end
        else if (w > 56'(TEMP_HIGH))
        begin
            temp_sat = TEMP_HIGH;
        end
        else
        begin
            temp_sat = 16'(w);
        end
    end

    // fan duty choice
    always_comb
    begin
        lo_th    = $signed({3'b0, cfg.target_temp}) - $signed({5'b0, cfg.hysteresis});
        hi_th    = $signed({3'b0, cfg.target_temp}) + $signed({5'b0, cfg.hysteresis});
        pit17    = {pit_t_reg[15], pit_t_reg};
        man_cap  = (cfg.manual_duty > DUTY_MAX) ? DUTY_MAX : cfg.manual_duty;
        auto_cap = (cfg.auto_duty > DUTY_MAX) ? DUTY_MAX : cfg.auto_duty;
        case (cfg.fan_mode)
            MODE_MANUAL: duty_nx = man_cap;
            MODE_AUTO:
            begin
                if (pit17 < lo_th)
                begin
                    duty_nx = auto_cap;
                end
                else if (hi_th < pit17)
                begin
                    duty_nx = '0;
                end
                else
                begin
                    duty_nx = held_reg;
                end
            end
            default:     duty_nx = '0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:   if (job_valid) state_next = B_SETUP;
            B_SETUP:  state_next = bad ? B_NEXT : B_NORM;
            B_NORM:   if (nrm_reg[63]) state_next = B_LOG;
            B_LOG:
            begin
                if (cnt_reg == 6'd23)
                begin
                    state_next = which_reg ? B_MSTART : B_NORM;
                end
            end
            B_MSTART: state_next = B_MWAIT;
            B_MWAIT:
            begin
                if (mul_rsp.done)
                begin
                    state_next = (op_reg == OP_CUB) ? B_DEN : B_MSTART;
                end
            end
            B_DEN:    state_next = B_CHK;
            B_CHK:
            begin
                if (den_reg == '0)
                begin
                    state_next = B_NEXT;
                end
                else if (mag[63:56] != '0)
                begin
                    state_next = B_FIN;
                end
                else
                begin
                    state_next = B_DIV;
                end
            end
            B_DIV:    if (cnt_reg == '0) state_next = B_FIN;
            B_FIN:    state_next = B_NEXT;
            B_NEXT:   state_next = probe_reg ? B_DUTY : B_SETUP;
            B_DUTY:   if (!out_valid_reg || result_ready) state_next = B_IDLE;
            default:  state_next = B_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        job_pop       = (state_reg == B_IDLE) && job_valid;
        out_load      = (state_reg == B_DUTY) && (!out_valid_reg || result_ready);
        mul_req.start = (state_reg == B_MSTART);
        mul_req.sh32  = (op_reg != OP_LN);
        case (op_reg)
            OP_LN:
            begin
                mul_req.x = {{33{lg_reg[30]}}, lg_reg};
                mul_req.y = $signed(LN2_Q32);
            end
            OP_SQ:
            begin
                mul_req.x = l_reg;
                mul_req.y = l_reg;
            end
            OP_CUBE:
            begin
                mul_req.x = t_reg;
                mul_req.y = l_reg;
            end
            OP_LIN:
            begin
                mul_req.x = {{16{cfg.coeff_b[47]}}, cfg.coeff_b};
                mul_req.y = l_reg;
            end
            default:
            begin
                mul_req.x = {{16{cfg.coeff_c[47]}}, cfg.coeff_c};
                mul_req.y = t_reg;
            end
        endcase
        result_valid = out_valid_reg;
        result       = out_reg;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                sref_reg  <= job[SW-1:0];
                spit_reg  <= job[2*SW-1:SW];
                sfood_reg <= job[3*SW-1:2*SW];
            end
            B_SETUP:
            begin
                d_reg     <= 64'(dval);
                nrm_reg   <= 64'(sp_ohm);
                exp_reg   <= 6'd63;
                which_reg <= 1'b0;
                tmp_reg   <= '0;
            end
            B_NORM:
            begin
                if (nrm_reg[63])
                begin
                    m_reg    <= nrm_reg[63:33];
                    frac_reg <= '0;
                    cnt_reg  <= '0;
                end
                else if (nrm_reg[63:56] == '0)
                begin
                    nrm_reg <= nrm_reg << 8;
                    exp_reg <= exp_reg - 6'd8;
                end
                else
                begin
                    nrm_reg <= nrm_reg << 1;
                    exp_reg <= exp_reg - 6'd1;
                end
            end
            B_LOG:
            begin
                m_reg    <= m_nx;
                frac_reg <= frac_nx;
                cnt_reg  <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd23)
                begin
                    if (!which_reg)
                    begin
                        logn_reg  <= {exp_reg, frac_nx};
                        which_reg <= 1'b1;
                        nrm_reg   <= d_reg;
                        exp_reg   <= 6'd63;
                    end
                    else
                    begin
                        lg_reg <= $signed({1'b0, logn_reg}) - $signed({1'b0, exp_reg, frac_nx});
                        op_reg <= OP_LN;
                    end
                end
            end
            B_MWAIT:
            begin
                if (mul_rsp.done)
                begin
                    case (op_reg)
                        OP_LN:   begin l_reg  <= mul_rsp.prod; op_reg <= OP_SQ;   end
                        OP_SQ:   begin t_reg  <= mul_rsp.prod; op_reg <= OP_CUBE; end
                        OP_CUBE: begin t_reg  <= mul_rsp.prod; op_reg <= OP_LIN;  end
                        OP_LIN:  begin mb_reg <= mul_rsp.prod; op_reg <= OP_CUB;  end
                        default: mc_reg <= mul_rsp.prod;
                    endcase
                end
            end
            B_DEN:
            begin
                den_reg <= {{16{cfg.coeff_a[47]}}, cfg.coeff_a} + mb_reg + mc_reg;
            end
            B_CHK:
            begin
                neg_reg <= den_reg[63];
                q_reg   <= '0;
                rem_reg <= '0;
                dvd_reg <= RECIP_NUM;
                cnt_reg <= 6'd55;
                dv_reg  <= 59'({mag[56:0], 2'b00}) + 59'(mag);
            end
            B_DIV:
            begin
                rem_reg <= ge ? 59'(rem_sh - {1'b0, dv_reg}) : rem_sh[58:0];
                q_reg   <= {q_reg[54:0], ge};
                dvd_reg <= dvd_reg << 1;
                cnt_reg <= cnt_reg - 6'd1;
            end
            B_FIN:
            begin
                tmp_reg <= temp_sat;
            end
            B_NEXT:
            begin
                if (probe_reg)
                begin
                    food_t_reg <= tmp_reg;
                end
                else
                begin
                    pit_t_reg <= tmp_reg;
                end
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_reg.pit_temp  <= pit_t_reg;
            out_reg.food_temp <= food_t_reg;
            out_reg.fan_duty  <= duty_nx;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            probe_reg     <= 1'b0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_IDLE)
            begin
                probe_reg <= 1'b0;
            end
            else if (state_reg == B_NEXT)
            begin
                probe_reg <= 1'b1;
            end
            if (out_load)
            begin
                held_reg      <= duty_nx;
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.fan_duty <= DUTY_MAX))
        else $error("fan duty above limit");
    a_pit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.pit_temp >= TEMP_LOW))
        else $error("pit temperature below saturation floor");
    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DIV) |-> (rem_reg < dv_reg))
        else $error("division remainder not reduced");
    a_mul_waited: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> (state_reg == B_MWAIT))
        else $error("multiplier result with nobody waiting");
`endif
endmodule

[hw/rtl/thermistor_hysteresis_fan_control.sv]
// Top level of the thermistor fan controller: configuration registers and wiring.
// Depends on thc_pkg, thc_front, thc_queue, thc_mul and thc_back.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------
//   item     | item_valid / item_ready    | thc_pkg::item_t
//   result   | result_valid / result_ready| thc_pkg::result_t
//   cfg      | cfg_we (no wait)           | cfg_addr, cfg_wdata (48 bits)
//
// A sample transfer occupies the front end for a ring read, then an update.
// In the conversion engine a report takes, per probe, two 24-step log2 loops on the
// squaring multiplier, five 64-bit products on the shared 32x32 multiplier,
// and a 56-step bit-serial reciprocal divider.
// Up to two reports queue between front and engine; one result waits in the output
// register while the next report runs. Reset needs no clearing pass: a fill flag
// makes ring slots not yet written read as zero.
module thermistor_hysteresis_fan_control #(
    parameter int WINDOW_LEN  = 64,
    parameter int VOLT_BITS   = 12,
    parameter int SERIES_OHMS = 10000
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  thc_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_ready,
    output thc_pkg::result_t  result,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_addr,
    input  logic [47:0]       cfg_wdata
);
    import thc_pkg::*;

    localparam int PW = $clog2(WINDOW_LEN);
    localparam int SW = VOLT_BITS + PW;

    cfg_t              cfg_reg;
    logic              q_push, q_not_full, q_not_empty, q_pop;
    logic [3*SW-1:0]   q_in, q_out;
    mul_req_t          mul_req;
    mul_rsp_t          mul_rsp;

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coeff_a     <= '0;
            cfg_reg.coeff_b     <= '0;
            cfg_reg.coeff_c     <= '0;
            cfg_reg.fan_mode    <= MODE_AUTO;
            cfg_reg.manual_duty <= '0;
            cfg_reg.auto_duty   <= 7'd100;
            cfg_reg.target_temp <= 14'd3600;
            cfg_reg.hysteresis  <= 12'd80;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_COEFF_A:     cfg_reg.coeff_a     <= cfg_wdata;
                REG_COEFF_B:     cfg_reg.coeff_b     <= cfg_wdata;
                REG_COEFF_C:     cfg_reg.coeff_c     <= cfg_wdata;
                REG_FAN_MODE:    cfg_reg.fan_mode    <= cfg_wdata[1:0];
                REG_MANUAL_DUTY: cfg_reg.manual_duty <= cfg_wdata[6:0];
                REG_AUTO_DUTY:   cfg_reg.auto_duty   <= cfg_wdata[6:0];
                REG_TARGET_TEMP: cfg_reg.target_temp <= cfg_wdata[13:0];
                REG_HYSTERESIS:  cfg_reg.hysteresis  <= cfg_wdata[11:0];
                default:         cfg_reg.hysteresis  <= cfg_reg.hysteresis;
            endcase
        end
    end

    thc_front #(
        .W  (WINDOW_LEN),
        .VB (VOLT_BITS),
        .PW (PW),
        .SW (SW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_ready    (q_not_full),
        .q_push     (q_push),
        .q_data     (q_in)
    );

    thc_queue #(
        .WIDTH (3 * SW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_out)
    );

    thc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    thc_back #(
        .SW          (SW),
        .SERIES_OHMS (SERIES_OHMS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .job_valid    (q_not_empty),
        .job_pop      (q_pop),
        .job          (q_out),
        .mul_req      (mul_req),
        .mul_rsp      (mul_rsp),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );
endmodule

[test/thermistor_hysteresis_fan_control_tb.sv]
// Self-checking testbench for thermistor_hysteresis_fan_control.
// Depends on thc_pkg and the block; drives samples, reports and register writes,
// and checks each reported temperature pair and fan duty against its own prediction.
module thermistor_hysteresis_fan_control_tb;
    import thc_pkg::*;

    localparam int WINDOW      = 64;
    localparam int SERIES      = 10000;
    localparam int STALL_LIMIT = 20000;

    // Prediction of the controller and the store of expected reports
    class report_board;
        result_t    pending[$];
        logic [11:0] ring[3][WINDOW];
        logic [63:0] sums[3];
        int          slot;
        logic [6:0]  held;
        longint      ca, cb, cc;
        logic [1:0]  mode;
        logic [6:0]  man_duty, hot_duty;
        logic [13:0] target;
        logic [11:0] band;
        int          errors;
        int          checked;

        function new();
            foreach (ring[c, i]) ring[c][i] = '0;
            foreach (sums[c]) sums[c] = '0;
            slot = 0; held = '0; errors = 0; checked = 0;
            ca = 0; cb = 0; cc = 0; mode = '0; man_duty = '0; hot_duty = 7'd100;
            target = 14'd3600; band = 12'd80;
        endfunction

        function void set_reg(logic [2:0] idx, logic [47:0] val);
            case (idx)
                REG_COEFF_A:     ca = longint'($signed(val));
                REG_COEFF_B:     cb = longint'($signed(val));
                REG_COEFF_C:     cc = longint'($signed(val));
                REG_FAN_MODE:    mode = val[1:0];
                REG_MANUAL_DUTY: man_duty = val[6:0];
                REG_AUTO_DUTY:   hot_duty = val[6:0];
                REG_TARGET_TEMP: target = val[13:0];
                REG_HYSTERESIS:  band = val[11:0];
                default: ;
            endcase
        endfunction

        // (x*y) >> sh, truncated toward zero, saturated
        function longint mul_shift(longint x, longint y, int sh);
            logic [63:0]  ux, uy;
            logic [127:0] p;
            logic         neg;
            neg = (x < 0) != (y < 0);
            ux = (x < 0) ? -x : x;
            uy = (y < 0) ? -y : y;
            p = {64'b0, ux} * {64'b0, uy};
            p = p >> sh;
            if (p[127:63] != 0) p = 128'h7FFF_FFFF_FFFF_FFFF;
            return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
        endfunction

        function longint log2_frac(logic [63:0] n);
            int          e;
            logic [63:0] m, frac;
            e = 0; frac = '0;
            while (e < 63 && (n >> (e + 1)) != 0) e++;
            m = (e <= 30) ? n << (30 - e) : n >> (e - 30);
            for (int i = 0; i < 24; i++)
            begin
                m = (m * m) >> 30;
                frac = frac << 1;
                if (m >= 64'h8000_0000)
                begin
                    m = m >> 1;
                    frac[0] = 1'b1;
                end
            end
            return (longint'(e) << 24) | longint'(frac);
        endfunction

        function logic signed [15:0] probe_temp(logic [63:0] sp, logic [63:0] sref);
            longint      lg, ln_r, ln_r3, den, v, w;
            logic [63:0] mag, q;
            if (sp == 0 || 2 * sref <= sp) return '0;
            lg = log2_frac(sp * SERIES) - log2_frac(2 * sref - sp);
            ln_r = mul_shift(lg, longint'(LN2_Q32), 24);
            ln_r3 = mul_shift(mul_shift(ln_r, ln_r, 32), ln_r, 32);
            den = ca + mul_shift(cb, ln_r, 32) + mul_shift(cc, ln_r3, 32);
            if (den == 0) return '0;
            mag = (den < 0) ? -den : den;
            q = (mag >= (64'd1 << 56)) ? 64'd0 : (64'd144 << 48) / (5 * mag);
            v = ((den < 0) ? -longint'(q) : longint'(q)) - K_OFFSET_Q8;
            w = (v + 128) >>> 8;
            if (w < TEMP_LOW) w = TEMP_LOW;
            if (w > TEMP_HIGH) w = TEMP_HIGH;
            return w[15:0];
        endfunction

        // Note an accepted input transfer and queue any report it causes
        function void note_item(item_t it);
            result_t     r;
            logic [11:0] nv[3];
            longint      pit, lo_th, hi_th;
            if (!it.cmd)
            begin
                nv[0] = it.ref_mv; nv[1] = it.pit_mv; nv[2] = it.food_mv;
                slot = (slot + 1) % WINDOW;
                for (int c = 0; c < 3; c++)
                begin
                    sums[c] = sums[c] - ring[c][slot] + nv[c];
                    ring[c][slot] = nv[c];
                end
                return;
            end
            r.pit_temp = probe_temp(sums[1], sums[0]);
            r.food_temp = probe_temp(sums[2], sums[0]);
            pit = r.pit_temp;
            lo_th = longint'(target) - longint'(band);
            hi_th = longint'(target) + longint'(band);
            if (mode == MODE_MANUAL) held = (man_duty > DUTY_MAX) ? DUTY_MAX : man_duty;
            else if (mode != MODE_AUTO) held = '0;
            else if (pit < lo_th) held = (hot_duty > DUTY_MAX) ? DUTY_MAX : hot_duty;
            else if (hi_th < pit) held = '0;
            r.fan_duty = held;
            pending.push_back(r);
        endfunction

        task report(string what);
            errors++;
            $display("mismatch at %0t: %s", $time, what);
        endtask

        task check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                report("report with none outstanding");
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.pit_temp !== want.pit_temp)
                report($sformatf("pit_temp %0d, want %0d", got.pit_temp, want.pit_temp));
            if (got.food_temp !== want.food_temp)
                report($sformatf("food_temp %0d, want %0d", got.food_temp, want.food_temp));
            if (got.fan_duty !== want.fan_duty)
                report($sformatf("fan_duty %0d, want %0d", got.fan_duty, want.fan_duty));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    item_t       item;
    logic        result_valid;
    logic        result_ready;
    result_t     result;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [47:0] cfg_wdata;

    report_board board;
    int          send_gap_pct;
    int          recv_gap_pct;
    int          hold_left;
    int          stall_count;
    int          n_items;
    int          n_reports;

    thermistor_hysteresis_fan_control u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata)
    );

    always #4 clk = ~clk;

    // Watch both channels: note inputs, check results, count stalled cycles
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
            begin
                board.note_item(item);
                n_items++;
                if (item.cmd) n_reports++;
            end
            if (result_valid && result_ready)
                board.check_result(result);
            if ((item_valid && item_ready) || (result_valid && result_ready))
                stall_count <= 0;
            else
                stall_count <= stall_count + 1;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= recv_gap_pct);
    end

    task automatic send(item_t it);
        while ($urandom_range(99) < send_gap_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do @(posedge clk); while (!item_ready);
    endtask

    task automatic send_sample(logic [11:0] r, logic [11:0] p, logic [11:0] f);
        item_t it;
        it.cmd = 1'b0; it.ref_mv = r; it.pit_mv = p; it.food_mv = f;
        send(it);
    endtask

    task automatic send_report();
        item_t it;
        it = '0;
        it.cmd = 1'b1;
        it.ref_mv = 12'($urandom); it.pit_mv = 12'($urandom); it.food_mv = 12'($urandom);
        send(it);
    endtask

    // Hold off the sender until every expected report has arrived
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [47:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        board.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic write_all(logic [47:0] a, logic [47:0] b, logic [47:0] c, logic [1:0] m,
                             logic [6:0] md, logic [6:0] ad, logic [13:0] t, logic [11:0] h);
        write_reg(REG_COEFF_A, a);
        write_reg(REG_COEFF_B, b);
        write_reg(REG_COEFF_C, c);
        write_reg(REG_FAN_MODE, {46'b0, m});
        write_reg(REG_MANUAL_DUTY, {41'b0, md});
        write_reg(REG_AUTO_DUTY, {41'b0, ad});
        write_reg(REG_TARGET_TEMP, {34'b0, t});
        write_reg(REG_HYSTERESIS, {36'b0, h});
        cfg_we <= 1'b0;
    endtask

    // Mostly plausible divider readings, sometimes anything at all
    task automatic random_traffic(int count);
        logic [11:0] r;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(4) == 0)
                send_report();
            else if ($urandom_range(9) == 0)
                send_sample(12'($urandom), 12'($urandom), 12'($urandom));
            else
            begin
                r = 12'($urandom_range(4095, 1500));
                send_sample(r, 12'($urandom_range(2 * r - 100, 50) % 4096),
                            12'($urandom_range(2 * r - 100, 50) % 4096));
            end
        end
    endtask

    localparam logic [47:0] SH_A = 48'd802660000;
    localparam logic [47:0] SH_B = 48'd237500000;
    localparam logic [47:0] SH_C = 48'd102260;

    initial
    begin
        board = new();
        clk = 1'b0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        send_gap_pct = 0;
        recv_gap_pct = 0;
        hold_left = 0;
        stall_count = 0;
        n_items = 0;
        n_reports = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty sums, reset registers, field extremes, bad dividers
        send_report();
        drain();
        write_all(SH_A, SH_B, SH_C, MODE_AUTO, 7'd0, 7'd100, 14'd3600, 12'd80);
        send_report();
        send_sample(12'hFFF, 12'hFFF, 12'hFFF);
        send_report();
        send_sample(12'd0, 12'd0, 12'd0);
        send_sample(12'd3300, 12'd0, 12'd1650);
        send_report();
        send_sample(12'd100, 12'd4095, 12'd4095);
        send_report();
        for (int i = 0; i < 6; i++) send_sample(12'd3300, 12'd1650, 12'd2400);
        send_report();
        send_sample(12'd3300, 12'd10, 12'd6000 % 4096);
        send_report();
        drain();
        // Zero denominator, negative denominator and vanishing reciprocal
        write_all(48'd0, 48'd0, 48'd0, 2'd3, 7'd127, 7'd127, 14'd16383, 12'd4095);
        send_report();
        drain();
        write_all(48'h8000_0000_0000, 48'd0, 48'd0, MODE_MANUAL, 7'd127, 7'd0, 14'd0, 12'd0);
        send_report();
        drain();
        write_all(48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, MODE_AUTO,
                  7'd55, 7'd127, 14'd0, 12'd0);
        send_report();
        send_report();
        drain();

        // Phase 1: sender seldom idles, receiver mostly stalls
        send_gap_pct = 7;
        recv_gap_pct = 77;
        write_all(SH_A, SH_B, SH_C, MODE_AUTO, 7'($urandom), 7'($urandom_range(100, 1)),
                  14'($urandom_range(6000, 1000)), 12'($urandom_range(400)));
        random_traffic(160);
        drain();

        // Phase 2: the other way round, A and B near the real coefficients, C random
        send_gap_pct = 77;
        recv_gap_pct = 7;
        write_all(SH_A + 48'($urandom_range(1 << 20)), SH_B - 48'($urandom_range(1 << 20)),
                  48'($urandom), MODE_MANUAL, 7'($urandom_range(127)), 7'($urandom),
                  14'd16383, 12'd4095);
        random_traffic(110);
        drain();

        // Phase 3: no idling; a long receiver hold-off fills the block up
        send_gap_pct = 0;
        recv_gap_pct = 0;
        write_all(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                  48'({$urandom, $urandom}), 2'd2,
                  7'($urandom), 7'($urandom), 14'($urandom), 12'($urandom));
        hold_left = 1500;
        random_traffic(80);
        drain();
        write_all(SH_A, SH_B, SH_C, MODE_AUTO, 7'd0, 7'($urandom_range(100)),
                  14'($urandom_range(5000, 2000)), 12'($urandom_range(2000)));
        random_traffic(90);
        drain();
        write_all(SH_A, SH_B, SH_C, MODE_AUTO, 7'd20, 7'd127, 14'd0, 12'd0);
        random_traffic(90);
        drain();
        write_all(SH_A, 48'd0, SH_C, MODE_AUTO, 7'd20, 7'd63, 14'($urandom), 12'd100);
        random_traffic(100);

        // Wrap up once every report has come back
        item_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        $display("covered %0d transfers in (%0d reports), %0d reports checked", n_items,
                 n_reports, board.checked);
        $display("across mode and coefficient sets, stalls, a long hold-off and register extremes");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
